// File: src/breakpoint_linear_interpolator_core_defines.svh
// Assertion macros for the breakpoint interpolator.
// Used by the RTL files that carry concurrent checks; no dependencies.
`ifndef BREAKPOINT_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define BREAKPOINT_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BLIN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define BLIN_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("check failed");
`else
`define BLIN_ASSERT(lbl, clk, rst, prop)
`define BLIN_ASSERT_IMPL(lbl, clk, rst, a, b)
`endif
`endif

// File: src/blin_pkg.sv
// Shared types and constants for the breakpoint interpolator.
// No dependencies.
package blin_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int AGE_W = 10;
  localparam int VAL_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int DIV_BITS = VAL_W + AGE_W;
  localparam int DIV_STEPS = 6;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
  localparam int LATENCY = DIV_STAGES + 6;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        idx;
    logic [AGE_W-1:0]        eage;
    logic signed [VAL_W-1:0] evalue;
    logic [AGE_W-1:0]        q;
    logic                    allow;
  } item_t;

  typedef struct packed {
    logic                    valid;
    logic                    beyond;
    logic                    over;
    logic                    below;
    logic                    same;
    logic                    allow;
    logic [AGE_W-1:0]        q;
    logic [AGE_W-1:0]        age_a;
    logic [AGE_W-1:0]        age_b;
    logic signed [VAL_W-1:0] val_a;
    logic signed [VAL_W-1:0] val_b;
  } rd_t;

  typedef struct packed {
    logic                    valid;
    logic                    direct;
    logic                    status;
    logic                    neg;
    logic signed [VAL_W-1:0] value;
  } tag_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] quot;
    logic [AGE_W-1:0]    rem;
    logic [AGE_W-1:0]    den;
  } div_t;
endpackage

// File: src/blin_lookup.sv
// Breakpoint table: parallel age compare, segment select and table read.
// Depends on blin_pkg.
module blin_lookup (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  blin_pkg::item_t         in_item,
  input  logic [blin_pkg::IDX_W-1:0] last_idx,
  output blin_pkg::rd_t           rd
);
  import blin_pkg::*;

  logic s1_valid, s2_valid;
  item_t s1, s2;
  logic [AGE_W-1:0] age_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le1, ge1, le2, ge2;
  logic [MAX_ENTRIES-1:0] ge_f;
  logic [IDX_W-1:0] lo, hi;
  logic found;
  logic [AGE_W-1:0] age_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] val_mem [MAX_ENTRIES];
  rd_t s3;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      le1[i] = age_r[i] <= s1.q;
      ge1[i] = age_r[i] >= s1.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
    s1 <= in_item;
    s2 <= s1;
    le2 <= le1;
    ge2 <= ge1;
    if (s1_valid && s1.op == OP_WRITE) begin
      age_r[s1.idx] <= s1.eage;
    end
  end

  always_comb begin
    ge_f = ge2;
    ge_f[last_idx] = 1'b1;
    hi = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!found && ge_f[i]) begin
        hi = IDX_W'(i);
        found = 1'b1;
      end
    end
    lo = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (le2[i] && IDX_W'(i) <= hi) begin
        lo = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= s2_valid && s2.op == OP_QUERY;
    end
    if (s2_valid && s2.op == OP_WRITE) begin
      age_mem[s2.idx] <= s2.eage;
      val_mem[s2.idx] <= s2.evalue;
    end
    s3.beyond <= le2[last_idx];
    s3.over   <= le2[last_idx] && !ge2[last_idx];
    s3.below  <= !le2[0];
    s3.same   <= lo == hi;
    s3.allow  <= s2.allow;
    s3.q      <= s2.q;
    s3.age_a  <= age_mem[lo];
    s3.val_a  <= val_mem[lo];
    s3.age_b  <= age_mem[le2[last_idx] ? last_idx : hi];
    s3.val_b  <= val_mem[le2[last_idx] ? last_idx : hi];
  end

  assign rd = s3;
endmodule

// File: src/blin_div_stage.sv
// One stage of the restoring divider: several quotient bits per cycle.
// Depends on blin_pkg.
module blin_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  blin_pkg::tag_t tag_in,
  input  blin_pkg::div_t div_in,
  output blin_pkg::tag_t tag_out,
  output blin_pkg::div_t div_out
);
  import blin_pkg::*;

  div_t d;
  logic [AGE_W:0] r2;

  always_comb begin
    d = div_in;
    r2 = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      r2 = {d.rem, d.dividend[DIV_BITS-1]};
      d.dividend = d.dividend << 1;
      if (r2 >= {1'b0, d.den}) begin
        d.rem = AGE_W'(r2 - {1'b0, d.den});
        d.quot = {d.quot[DIV_BITS-2:0], 1'b1};
      end else begin
        d.rem = r2[AGE_W-1:0];
        d.quot = {d.quot[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    div_out <= d;
  end
endmodule

// File: src/breakpoint_linear_interpolator_core.sv
// Breakpoint interpolator top level: config, lookup, multiply, divide, saturate.
// result_valid for an accepted query is registered after s1, s2, s3 (lookup), s4, s5,
// the divider stages and the output register; one item per cycle.
// Throughput set by the fully pipelined lookup and the 7-stage divider chain.
// Write items produce no result. busy follows rst; results cannot be stalled.
// Synchronous reset clears valid bits and sets entries_in_use to 1.
`include "breakpoint_linear_interpolator_core_defines.svh"
module breakpoint_linear_interpolator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [blin_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           op,
  input  logic [blin_pkg::IDX_W-1:0]     entry_index,
  input  logic [blin_pkg::AGE_W-1:0]     entry_age,
  input  logic signed [blin_pkg::VAL_W-1:0] entry_value,
  input  logic [blin_pkg::AGE_W-1:0]     query_age,
  input  logic                           allow_beyond_last,
  output logic                           result_valid,
  output logic signed [blin_pkg::VAL_W-1:0] result_value,
  output logic                           status
);
  import blin_pkg::*;

  logic [CNT_W-1:0] entries_in_use;
  logic [IDX_W-1:0] last_idx;
  item_t item;
  rd_t rd;
  tag_t s4_tag, s4_tag_next, s5_tag, s5_tag_next;
  logic signed [VAL_W:0] s4_diff, diff_next;
  logic [AGE_W-1:0] s4_num, s4_den, num_next, den_next;
  logic signed [AGE_W:0] span, off;
  logic signed [VAL_W+AGE_W+1:0] prod;
  logic prod_neg;
  div_t s5_div;
  tag_t tags [DIV_STAGES+1];
  div_t divs [DIV_STAGES+1];
  logic signed [DIV_BITS:0] quot_s;
  logic signed [DIV_BITS+1:0] sum;
  logic signed [VAL_W-1:0] sat;
  logic signed [DIV_BITS+1:0] vmax, vmin;

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (entries_in_use == '0) begin
      last_idx = '0;
    end else if (entries_in_use > CNT_W'(MAX_ENTRIES)) begin
      last_idx = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(entries_in_use - CNT_W'(1));
    end
  end

  assign item = '{op: op, idx: entry_index, eage: entry_age, evalue: entry_value,
                  q: query_age, allow: allow_beyond_last};

  blin_lookup u_lookup (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_item(item),
    .last_idx(last_idx), .rd(rd)
  );

  always_comb begin
    s4_tag_next = '{valid: rd.valid, direct: 1'b1, status: 1'b0, neg: 1'b0, value: '0};
    diff_next = '0;
    num_next = '0;
    den_next = '0;
    span = $signed({1'b0, rd.age_b}) - $signed({1'b0, rd.age_a});
    off = $signed({1'b0, rd.q}) - $signed({1'b0, rd.age_a});
    if (rd.beyond) begin
      if (rd.over && !rd.allow) begin
        s4_tag_next.status = 1'b1;
      end else begin
        s4_tag_next.value = rd.val_b;
      end
    end else if (rd.below) begin
      s4_tag_next.direct = 1'b0;
      diff_next = (VAL_W+1)'(rd.val_a);
      num_next = rd.q;
      den_next = rd.age_a;
    end else if (rd.same) begin
      s4_tag_next.value = rd.val_b;
    end else if (span <= 0 || off < 0 || off >= span) begin
      s4_tag_next.value = rd.val_a;
    end else begin
      s4_tag_next.direct = 1'b0;
      s4_tag_next.value = rd.val_a;
      diff_next = (VAL_W+1)'(rd.val_b) - (VAL_W+1)'(rd.val_a);
      num_next = off[AGE_W-1:0];
      den_next = span[AGE_W-1:0];
    end
  end

  assign prod = (VAL_W+AGE_W+2)'(s4_diff) * (VAL_W+AGE_W+2)'($signed({1'b0, s4_num}));
  assign prod_neg = prod < 0;

  always_comb begin
    s5_tag_next = s4_tag;
    s5_tag_next.neg = prod_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag <= '0;
      s5_tag <= '0;
    end else begin
      s4_tag <= s4_tag_next;
      s5_tag <= s5_tag_next;
    end
    s4_diff <= diff_next;
    s4_num <= num_next;
    s4_den <= den_next;
    s5_div.dividend <= DIV_BITS'(prod_neg ? -prod : prod);
    s5_div.quot <= '0;
    s5_div.rem <= '0;
    s5_div.den <= s4_den;
  end

  assign tags[0] = s5_tag;
  assign divs[0] = s5_div;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    blin_div_stage u_stage (
      .clk(clk), .rst(rst), .tag_in(tags[g]), .div_in(divs[g]),
      .tag_out(tags[g+1]), .div_out(divs[g+1])
    );
  end

  always_comb begin
    quot_s = tags[DIV_STAGES].neg ? -$signed({1'b0, divs[DIV_STAGES].quot})
                                  : $signed({1'b0, divs[DIV_STAGES].quot});
    sum = (DIV_BITS+2)'(tags[DIV_STAGES].value) + (DIV_BITS+2)'(quot_s);
    vmax = (DIV_BITS+2)'({1'b0, {(VAL_W-1){1'b1}}});
    vmin = -vmax - 1;
    if (sum > vmax) begin
      sat = VAL_W'(vmax);
    end else if (sum < vmin) begin
      sat = VAL_W'(vmin);
    end else begin
      sat = VAL_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tags[DIV_STAGES].valid;
    end
    result_value <= tags[DIV_STAGES].direct ? tags[DIV_STAGES].value : sat;
    status <= tags[DIV_STAGES].status;
  end

  `BLIN_ASSERT(a_result_follows_query, clk, rst, result_valid == $past(start && !busy && op == OP_QUERY, LATENCY))
  `BLIN_ASSERT_IMPL(a_error_zero, clk, rst, result_valid && status, result_value == '0)
  `BLIN_ASSERT_IMPL(a_count_clamped, clk, rst, entries_in_use == '0, last_idx == '0)
endmodule

// File: sim/breakpoint_linear_interpolator_core_tb.sv
// Testbench for breakpoint_linear_interpolator_core: loads breakpoint tables, sends queries
// and checks each strobed result against a predictor kept in step with every accepted item.
// Depends on blin_pkg and the core RTL.
`timescale 1ns / 100ps
module breakpoint_linear_interpolator_core_tb;
  import blin_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic op = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  logic [AGE_W-1:0] entry_age = '0;
  logic signed [VAL_W-1:0] entry_value = '0;
  logic [AGE_W-1:0] query_age = '0;
  logic allow_beyond_last = 1'b0;
  logic result_valid;
  logic signed [VAL_W-1:0] result_value;
  logic status;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    st;
  } interp_t;

  logic [AGE_W-1:0]        bp_age [MAX_ENTRIES];
  logic signed [VAL_W-1:0] bp_value [MAX_ENTRIES];
  int unsigned             entries_model = 1;
  interp_t                 pending_interp [$];
  int                      mismatches = 0;
  int                      send_idle_pct = 0;

  breakpoint_linear_interpolator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .op(op), .entry_index(entry_index), .entry_age(entry_age),
    .entry_value(entry_value), .query_age(query_age),
    .allow_beyond_last(allow_beyond_last), .result_valid(result_valid),
    .result_value(result_value), .status(status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint sat_value(longint v);
    longint vmax;
    vmax = (64'sd1 <<< (VAL_W - 1)) - 1;
    if (v > vmax) return vmax;
    if (v < -vmax - 1) return -vmax - 1;
    return v;
  endfunction

  function automatic longint scaled_step(longint d, longint num, longint den);
    if (den <= 0) return 0;
    return (d / den) * num + ((d % den) * num) / den;
  endfunction

  function automatic interp_t interpolate(logic [AGE_W-1:0] q, logic allow);
    interp_t r;
    int unsigned n;
    int lo, hi;
    longint span, off;
    n = entries_model;
    if (n == 0) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    r.value = '0;
    r.st = 1'b0;
    if (q >= bp_age[n-1]) begin
      if (!allow && q > bp_age[n-1]) r.st = 1'b1;
      else r.value = bp_value[n-1];
    end else if (q < bp_age[0]) begin
      r.value = sat_value(scaled_step(bp_value[0], q, bp_age[0]));
    end else begin
      lo = 0;
      hi = n - 1;
      for (int i = 0; i < n; i++) begin
        if (bp_age[i] <= q) lo = i;
        if (bp_age[i] >= q) begin
          hi = i;
          break;
        end
      end
      if (lo == hi) begin
        r.value = bp_value[hi];
      end else begin
        span = longint'(bp_age[hi]) - longint'(bp_age[lo]);
        off = longint'(q) - longint'(bp_age[lo]);
        if (span <= 0 || off < 0 || off >= span) r.value = bp_value[lo];
        else r.value = sat_value(longint'(bp_value[lo]) + scaled_step(
            longint'(bp_value[hi]) - longint'(bp_value[lo]), off, span));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    interp_t e;
    if (!rst && result_valid) begin
      if (pending_interp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", result_value, status);
      end else begin
        e = pending_interp.pop_front();
        if (result_value !== e.value || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b actual %h/%b", e.value, e.st,
                     result_value, status);
        end
      end
    end
  end

  task automatic send_item(logic o, logic [IDX_W-1:0] idx, logic [AGE_W-1:0] a,
                           logic signed [VAL_W-1:0] v, logic [AGE_W-1:0] q, logic al);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    entry_index <= idx;
    entry_age <= a;
    entry_value <= v;
    query_age <= q;
    allow_beyond_last <= al;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (o == OP_WRITE) begin
      bp_age[idx] = a;
      bp_value[idx] = v;
    end else begin
      pending_interp.insert(pending_interp.size(), interpolate(q, al));
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_interp.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_count(int unsigned n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    entries_model = n;
  endtask

  // increasing ages over all slots, stepping by at most gap + 1
  task automatic load_table(int unsigned gap, bit extreme_values);
    int unsigned a;
    logic signed [VAL_W-1:0] v;
    a = $urandom_range(gap);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (a > 1023) a = 1023 - (MAX_ENTRIES - 1 - i);
      v = extreme_values ? (($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000)
                         : VAL_W'($urandom);
      send_item(OP_WRITE, IDX_W'(i), AGE_W'(a), v, AGE_W'($urandom), 1'($urandom));
      a = a + 1 + $urandom_range(gap);
    end
  endtask

  function automatic int unsigned used_count();
    int unsigned n;
    n = entries_model;
    if (n == 0) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    return n;
  endfunction

  task automatic test_directed();
    send_item(OP_WRITE, 0, 10'd0, 32'sh7fffffff, 0, 0);
    send_item(OP_WRITE, 1, 10'd1023, 32'sh80000000, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 10'd0, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd5, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd5, 1'b1);
    write_count(2);
    send_item(OP_QUERY, 0, 0, 0, 10'd512, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd1023, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd1, 1'b1);
    send_item(OP_WRITE, 0, 10'd100, 32'sh80000000, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 10'd50, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd0, 1'b0);
    send_item(OP_WRITE, 0, 10'd1023, 32'sh12345678, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 10'd1023, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, 10'd300, 1'b0);
    write_count(0);
    send_item(OP_QUERY, 0, 0, 0, 10'd7, 1'b1);
    write_count(31);
    load_table(60, 1'b1);
    send_item(OP_QUERY, 0, 0, 0, AGE_W'(bp_age[3] + 1), 1'b1);
    send_item(OP_QUERY, 0, 0, 0, 10'd1023, 1'b0);
    send_item(OP_QUERY, 0, 0, 0, bp_age[7], 1'b0);
  endtask

  task automatic test_random(int items, int idle_pct);
    int unsigned n, k;
    logic [AGE_W-1:0] q;
    send_idle_pct = idle_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 100 == 0) begin
        write_count($urandom_range(31));
        load_table($urandom_range(1) ? 3 : 63, $urandom_range(3) == 0);
      end
      n = used_count();
      k = $urandom_range(9);
      if (k == 0) begin
        send_item(OP_WRITE, IDX_W'($urandom), AGE_W'($urandom), VAL_W'($urandom),
                  AGE_W'($urandom), 1'($urandom));
      end else begin
        if (k < 4) q = AGE_W'(bp_age[$urandom_range(n - 1)] + $urandom_range(2) - 1);
        else if (k < 8) q = AGE_W'($urandom_range(bp_age[n-1] + 1));
        else q = AGE_W'($urandom);
        send_item(OP_QUERY, IDX_W'($urandom), AGE_W'($urandom), VAL_W'($urandom), q,
                  1'($urandom));
      end
    end
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0);
    test_random(250, 50);
    drain_results();
    test_random(200, 50);
    test_random(250, 30);
    drain_results();
    if (mismatches == 0 && pending_interp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
